// ----- sv/bol_pkg.sv -----
// bol_pkg: command and status codes and fixed field widths of the bounded ordered list
// no dependencies; used by bol_mem and bounded_ordered_list
package bol_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_DEL_HEAD  = 3'd1,
		CMD_DEL_TAIL  = 3'd2,
		CMD_DEL_AFTER = 3'd3,
		CMD_READ_OUT  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOAFTER = 2'd3
	} status_t;

endpackage

// ----- sv/bol_mem.sv -----
// bol_mem: element store, one write port and one read port with registered read data
// depends on bol_pkg for the data width
module bol_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [bol_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [bol_pkg::DATA_W-1:0] rdata
);

	logic [bol_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/bounded_ordered_list.sv -----
// bounded_ordered_list: top level with the command sequencer, element count and result registers
// depends on bol_pkg and bol_mem
//
// usage:
//   a command transaction is taken at a rising edge with start high and busy low:
//   command, value (append only) and position (delete after position only).
//   results come out on status, element, count and last, each marked by done, which is
//   high for a single cycle per result; the receiver cannot stall, so it must take every result.
//   result timing and throughput:
//   - append, delete tail, errors, unused codes: result in the cycle after the command,
//     busy stays low, so a new command can follow every cycle
//   - delete head / delete after position: the store copies one element a cycle to
//     close the gap; the result is loaded with the last copy, busy meanwhile; removing
//     the last element needs no copy and answers in the cycle after the command
//   - read out: one result per element every cycle, the first after the read pointer and
//     the store's read register; busy until the last is loaded; an empty list gives one
//     result; the sequencer and the one read port and one write port of the store set this timing.
//   reset clears the count and the sequencer; the store itself is not cleared, only
//   entries below the count are ever read.
module bounded_ordered_list #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [bol_pkg::CMD_W-1:0]         command,
	input  logic signed [bol_pkg::DATA_W-1:0] value,
	input  logic [bol_pkg::POS_W-1:0]         position,
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [bol_pkg::DATA_W-1:0] element,
	output logic [$clog2(DEPTH+1)-1:0]        count,
	output logic                              last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (CW > bol_pkg::POS_W + 1) ? CW : bol_pkg::POS_W + 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SHIFT = 3'b010,
		S_READ  = 3'b100
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              ptr_q;
	logic [AW-1:0]              wa_q;
	logic                       wv_q;
	logic                       rv_q;
	logic                       rlast_q;
	logic                       done_q;
	bol_pkg::status_t           status_q;
	logic [bol_pkg::DATA_W-1:0] element_q;
	logic [CW-1:0]              count_q;
	logic                       last_q;

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [bol_pkg::DATA_W-1:0] mem_wdata;
	logic [bol_pkg::DATA_W-1:0] mem_rdata;

	logic          accept;
	logic          full;
	logic          empty;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] cnt_x;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	// index of the element that delete after position removes
	assign idx_x  = XW'(position) + XW'(1);
	assign cnt_x  = XW'(cnt_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = value;
		if (accept && (command == bol_pkg::CMD_APPEND) && !full) begin
			mem_we = 1'b1;
		end
		if ((state_q == S_SHIFT) && wv_q) begin
			mem_we    = 1'b1;
			mem_waddr = wa_q;
			mem_wdata = mem_rdata;
		end
	end

	bol_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ptr_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			wa_q      <= '0;
			wv_q      <= 1'b0;
			rv_q      <= 1'b0;
			rlast_q   <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= bol_pkg::ST_OK;
			element_q <= '0;
			count_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q  <= bol_pkg::ST_OK;
						element_q <= '0;
						count_q   <= cnt_q;
						last_q    <= 1'b1;
						done_q    <= 1'b1;
						case (command)
							bol_pkg::CMD_APPEND: begin
								if (full) begin
									status_q <= bol_pkg::ST_FULL;
								end else begin
									cnt_q   <= cnt_q + CW'(1);
									count_q <= cnt_q + CW'(1);
								end
							end
							bol_pkg::CMD_DEL_HEAD: begin
								if (empty) begin
									status_q <= bol_pkg::ST_EMPTY;
								end else if (cnt_q == CW'(1)) begin
									cnt_q   <= cnt_q - CW'(1);
									count_q <= cnt_q - CW'(1);
								end else begin
									done_q  <= 1'b0;
									ptr_q   <= CW'(1);
									wv_q    <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							bol_pkg::CMD_DEL_TAIL: begin
								if (empty) begin
									status_q <= bol_pkg::ST_EMPTY;
								end else begin
									cnt_q   <= cnt_q - CW'(1);
									count_q <= cnt_q - CW'(1);
								end
							end
							bol_pkg::CMD_DEL_AFTER: begin
								if (empty) begin
									status_q <= bol_pkg::ST_EMPTY;
								end else if (idx_x >= cnt_x) begin
									status_q <= bol_pkg::ST_NOAFTER;
								end else if (idx_x + XW'(1) == cnt_x) begin
									// removing the tail, nothing to move
									cnt_q   <= cnt_q - CW'(1);
									count_q <= cnt_q - CW'(1);
								end else begin
									done_q  <= 1'b0;
									ptr_q   <= CW'(idx_x + XW'(1));
									wv_q    <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							bol_pkg::CMD_READ_OUT: begin
								if (empty) begin
									status_q <= bol_pkg::ST_EMPTY;
								end else begin
									done_q  <= 1'b0;
									ptr_q   <= '0;
									rv_q    <= 1'b0;
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					// read at ptr, write the word in the next cycle one slot lower
					if (ptr_q < cnt_q) begin
						wv_q  <= 1'b1;
						wa_q  <= ptr_q[AW-1:0] - AW'(1);
						ptr_q <= ptr_q + CW'(1);
					end else begin
						wv_q      <= 1'b0;
						cnt_q     <= cnt_q - CW'(1);
						status_q  <= bol_pkg::ST_OK;
						element_q <= '0;
						count_q   <= cnt_q - CW'(1);
						last_q    <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_READ: begin
					if (rv_q) begin
						status_q  <= bol_pkg::ST_OK;
						element_q <= mem_rdata;
						count_q   <= cnt_q;
						last_q    <= rlast_q;
						done_q    <= 1'b1;
					end
					if (ptr_q < cnt_q) begin
						rv_q    <= 1'b1;
						rlast_q <= (ptr_q + CW'(1) == cnt_q);
						ptr_q   <= ptr_q + CW'(1);
					end else begin
						rv_q    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign status  = status_q;
	assign element = $signed(element_q);
	assign count   = count_q;
	assign last    = last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_cmd_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted command gave neither a result nor busy");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> busy)
		else $error("non-final result while sequencer idle");

	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && wv_q) |-> (CW'(wa_q) + CW'(1) < cnt_q))
		else $error("gap close writes outside the list");
`endif

endmodule

// ----- tb/bounded_ordered_list_test.sv -----
`timescale 1ns / 1ps
// bounded_ordered_list_test: self-checking testbench for the bounded ordered list
// depends on bol_pkg and bounded_ordered_list; commands go in through start/busy and every
// result is compared with a list kept inside the testbench
module bounded_ordered_list_test;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMD_W = bol_pkg::CMD_W;
	localparam int DATA_W = bol_pkg::DATA_W;
	localparam int POS_W = bol_pkg::POS_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTED = 100;
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} list_cmd_t;

	typedef struct {
		bol_pkg::status_t         status;
		logic signed [DATA_W-1:0] element;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0] position = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [DATA_W-1:0] element;
	logic [CNT_W-1:0] count;
	logic last;

	list_cmd_t pending_cmds[$];
	list_result_t expected_results[$];
	logic signed [DATA_W-1:0] list_contents[$];
	int idle_pct = 0;
	int mismatches = 0;
	int cycle_cnt = 0;

	bounded_ordered_list #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.position(position),
		.done(done),
		.status(status),
		.element(element),
		.count(count),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string what, longint want, longint got);
		if (mismatches < MAX_PRINTED)
			$display("mismatch @%0t: %s expected %0d got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	// apply one command to the list copy and queue the results it must produce
	task automatic predict_list_results(list_cmd_t c);
		list_result_t r;
		int idx;
		r.status = bol_pkg::ST_OK;
		r.element = '0;
		r.last = 1'b1;
		case (c.cmd)
		bol_pkg::CMD_APPEND: begin
			if (list_contents.size() >= DEPTH)
				r.status = bol_pkg::ST_FULL;
			else
				list_contents.push_back(c.value);
		end
		bol_pkg::CMD_DEL_HEAD: begin
			if (list_contents.size() == 0)
				r.status = bol_pkg::ST_EMPTY;
			else
				list_contents.delete(0);
		end
		bol_pkg::CMD_DEL_TAIL: begin
			if (list_contents.size() == 0)
				r.status = bol_pkg::ST_EMPTY;
			else
				list_contents.delete(list_contents.size() - 1);
		end
		bol_pkg::CMD_DEL_AFTER: begin
			idx = int'(c.position) + 1;
			if (list_contents.size() == 0)
				r.status = bol_pkg::ST_EMPTY;
			else if (idx >= list_contents.size())
				r.status = bol_pkg::ST_NOAFTER;
			else
				list_contents.delete(idx);
		end
		bol_pkg::CMD_READ_OUT: begin
			if (list_contents.size() == 0) begin
				r.status = bol_pkg::ST_EMPTY;
			end else begin
				for (int i = 0; i < list_contents.size(); i++) begin
					r.element = list_contents[i];
					r.count = CNT_W'(list_contents.size());
					r.last = (i == list_contents.size() - 1);
					expected_results.push_back(r);
				end
				return;
			end
		end
		default: begin
		end
		endcase
		r.count = CNT_W'(list_contents.size());
		expected_results.push_back(r);
	endtask

	// driver: hold the current command until it is taken, then maybe pause
	always @(posedge clk) begin
		bit taken;
		taken = start && !busy;
		if (taken)
			predict_list_results(pending_cmds.pop_front());
		if (arst_n && (!start || taken)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				command <= pending_cmds[0].cmd;
				value <= pending_cmds[0].value;
				position <= pending_cmds[0].position;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done cycle carries one result transaction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done !== 1'b0) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", -1, status);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", want.status, status);
				if (element !== want.element)
					report_mismatch("element", want.element, element);
				if (count !== want.count)
					report_mismatch("count", want.count, count);
				if (last !== want.last)
					report_mismatch("last", want.last, last);
			end
		end
	end

	task automatic add_cmd(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
		logic [POS_W-1:0] p);
		list_cmd_t item;
		item.cmd = c;
		item.value = v;
		item.position = p;
		pending_cmds.push_back(item);
	endtask

	task automatic add_random_cmd(int append_pct);
		int r;
		logic [CMD_W-1:0] c;
		r = $urandom_range(99);
		if (r < append_pct)
			c = bol_pkg::CMD_APPEND;
		else if (r < append_pct + 5)
			c = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		else
			c = CMD_W'($urandom_range(bol_pkg::CMD_DEL_HEAD, bol_pkg::CMD_READ_OUT));
		add_cmd(c, DATA_W'($urandom), POS_W'($urandom_range(15)));
	endtask

	task automatic wait_list_idle();
		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase_idle[4];
		phase_idle = '{0, 85, 0, 14};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// errors on the empty list and the unused codes
		add_cmd(bol_pkg::CMD_READ_OUT, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_HEAD, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_TAIL, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_AFTER, '0, '0);
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			add_cmd(CMD_W'(c), '1, '1);
		// extreme values, then deletes past the end, in the middle and at both ends of the list
		add_cmd(bol_pkg::CMD_APPEND, 32'sh7fffffff, '0);
		add_cmd(bol_pkg::CMD_APPEND, 32'sh80000000, '1);
		add_cmd(bol_pkg::CMD_APPEND, '0, '0);
		add_cmd(bol_pkg::CMD_APPEND, -32'sd1, '0);
		add_cmd(bol_pkg::CMD_DEL_AFTER, '0, 4'd3);
		add_cmd(bol_pkg::CMD_DEL_AFTER, '0, 4'd15);
		add_cmd(bol_pkg::CMD_READ_OUT, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_AFTER, '0, 4'd0);
		add_cmd(bol_pkg::CMD_DEL_HEAD, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_TAIL, '0, '0);
		add_cmd(bol_pkg::CMD_READ_OUT, '0, '0);
		add_cmd(bol_pkg::CMD_DEL_TAIL, '0, '0);
		add_cmd(bol_pkg::CMD_READ_OUT, '0, '0);
		wait_list_idle();

		// alternate filling and draining so both full and empty are hit often
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			for (int i = 0; i < 100; i++)
				add_random_cmd(((i / 25) % 2 == 0) ? 75 : 20);
			wait_list_idle();
		end

		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/bol_pkg.sv
sv/bol_mem.sv
sv/bounded_ordered_list.sv
tb/bounded_ordered_list_test.sv
